### rtl/image_magic_byte_classifier_macros.svh
// Assertion macros for the image magic-byte classifier.
// Expects clk and rst_n in the scope of each use.
`ifndef IMAGE_MAGIC_BYTE_CLASSIFIER_MACROS_SVH
`define IMAGE_MAGIC_BYTE_CLASSIFIER_MACROS_SVH

// same-cycle implication
`define IMBC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define IMBC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/imbc_pkg.sv
// Types, signature constants and compare functions for the classifier.
// No dependencies.
package imbc_pkg;

  localparam int SIG_COUNT  = 10;
  localparam int SIG_MAXLEN = 27;
  localparam int POS_W      = 5;
  localparam int CNT_W      = POS_W + 1;
  localparam int KIND_W     = 4;

  localparam logic [POS_W-1:0]     POS_MAX   = '1;
  localparam logic [SIG_COUNT-1:0] ALL_ALIVE = '1;

  typedef enum logic [KIND_W-1:0] {
    KIND_JPEG    = 4'd0,
    KIND_XBM     = 4'd1,
    KIND_SUNICON = 4'd2,
    KIND_XPM     = 4'd3,
    KIND_GIF     = 4'd4,
    KIND_PNM     = 4'd5,
    KIND_PNG     = 4'd6,
    KIND_BMP     = 4'd7,
    KIND_ICO     = 4'd8,
    KIND_UNKNOWN = 4'd9
  } kind_t;

  typedef enum logic [3:0] {
    SIG_JPEG    = 4'd0,
    SIG_XBM     = 4'd1,
    SIG_SUNICON = 4'd2,
    SIG_XPM     = 4'd3,
    SIG_GIF     = 4'd4,
    SIG_PNM     = 4'd5,
    SIG_PNG     = 4'd6,
    SIG_BMP     = 4'd7,
    SIG_ICO_IC  = 4'd8,
    SIG_ICO_CI  = 4'd9
  } sig_t;

  typedef logic [8*SIG_MAXLEN-1:0] sig_str_t;

  localparam sig_str_t STR_JPEG    = sig_str_t'(16'hFFD8);
  localparam sig_str_t STR_XBM     = sig_str_t'("#define ");
  // old Sun icon header text, as ASCII
  localparam sig_str_t STR_SUNICON = sig_str_t'({104'h2F2A20466F726D61745F766572,
                                                 112'h73696F6E3D312C2057696474683D});
  localparam sig_str_t STR_XPM     = sig_str_t'("/* XPM */");
  localparam sig_str_t STR_GIF     = sig_str_t'("GIF8");
  localparam sig_str_t STR_PNM     = sig_str_t'("P1");
  localparam sig_str_t STR_PNG     = sig_str_t'(64'h89504E470D0A1A0A);
  localparam sig_str_t STR_BMP     = sig_str_t'("BM");
  localparam sig_str_t STR_ICO_IC  = sig_str_t'("IC");
  localparam sig_str_t STR_ICO_CI  = sig_str_t'("CI");

  typedef struct packed {
    logic                 fire;
    logic [SIG_COUNT-1:0] alive;
    logic [CNT_W-1:0]     count;
  } match_res_t;

  function automatic logic [POS_W-1:0] sig_len(sig_t s);
    logic [POS_W-1:0] len;
    unique case (s)
      SIG_XBM, SIG_PNG: len = 5'd8;
      SIG_SUNICON:      len = 5'd27;
      SIG_XPM:          len = 5'd9;
      SIG_GIF:          len = 5'd4;
      default:          len = 5'd2;
    endcase
    return len;
  endfunction

  function automatic logic [POS_W-1:0] sig_need(sig_t s);
    logic [POS_W-1:0] need;
    if (s == SIG_JPEG) begin
      need = 5'd3;
    end else begin
      need = sig_len(s);
    end
    return need;
  endfunction

  function automatic kind_t sig_kind(sig_t s);
    kind_t k;
    unique case (s)
      SIG_JPEG:               k = KIND_JPEG;
      SIG_XBM:                k = KIND_XBM;
      SIG_SUNICON:            k = KIND_SUNICON;
      SIG_XPM:                k = KIND_XPM;
      SIG_GIF:                k = KIND_GIF;
      SIG_PNM:                k = KIND_PNM;
      SIG_PNG:                k = KIND_PNG;
      SIG_BMP:                k = KIND_BMP;
      SIG_ICO_IC, SIG_ICO_CI: k = KIND_ICO;
      default:                k = KIND_UNKNOWN;
    endcase
    return k;
  endfunction

  function automatic sig_str_t sig_str(sig_t s);
    sig_str_t str;
    unique case (s)
      SIG_JPEG:    str = STR_JPEG;
      SIG_XBM:     str = STR_XBM;
      SIG_SUNICON: str = STR_SUNICON;
      SIG_XPM:     str = STR_XPM;
      SIG_GIF:     str = STR_GIF;
      SIG_PNM:     str = STR_PNM;
      SIG_PNG:     str = STR_PNG;
      SIG_BMP:     str = STR_BMP;
      SIG_ICO_IC:  str = STR_ICO_IC;
      SIG_ICO_CI:  str = STR_ICO_CI;
      default:     str = '0;
    endcase
    return str;
  endfunction

  // 1 unless the byte at pos lies inside the signature and differs (PNM: second byte outside '1'-'7')
  function automatic logic sig_ok(sig_t s, logic [POS_W-1:0] pos, logic [7:0] b);
    logic             ok;
    logic [POS_W-1:0] len;
    logic [POS_W-1:0] rev;
    sig_str_t         str;
    len = sig_len(s);
    str = sig_str(s);
    rev = len - pos - 5'd1;
    ok  = 1'b1;
    if (pos < len) begin
      if (s == SIG_PNM && pos == 5'd1) begin
        ok = (b >= 8'h31) && (b <= 8'h37);
      end else begin
        ok = (b == str[8*rev +: 8]);
      end
    end
    return ok;
  endfunction

endpackage

### rtl/imbc_in_stage.sv
// Input register stage of the classifier: holds one word, drives in_stall.
// No dependencies.
module imbc_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_is_last,
  input  logic       out_free,
  output logic       go,
  output logic [7:0] data,
  output logic       last
);

  logic       valid_r, valid_nxt;
  logic [7:0] data_r, data_nxt;
  logic       last_r, last_nxt;

  // a non-final word never needs the output slot
  assign go       = valid_r && (!last_r || out_free);
  assign in_stall = valid_r && !go;
  assign data     = data_r;
  assign last     = last_r;

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    last_nxt  = last_r;
    if (!in_stall) begin
      valid_nxt = in_valid;
      data_nxt  = in_data_byte;
      last_nxt  = in_is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    data_r <= data_nxt;
    last_r <= last_nxt;
  end

endmodule

### rtl/imbc_match.sv
// Byte position and per-signature match bits; updates on each word.
// Depends on imbc_pkg and the macros header.
`include "image_magic_byte_classifier_macros.svh"

module imbc_match (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                go,
  input  logic [7:0]          data,
  input  logic                last,
  output imbc_pkg::match_res_t res
);

  logic [imbc_pkg::POS_W-1:0]     pos_r, pos_nxt;
  logic [imbc_pkg::SIG_COUNT-1:0] alive_r, alive_nxt;
  logic [imbc_pkg::SIG_COUNT-1:0] alive_upd;

  always_comb begin
    for (int i = 0; i < imbc_pkg::SIG_COUNT; i++) begin
      alive_upd[i] = alive_r[i] &&
                     imbc_pkg::sig_ok(imbc_pkg::sig_t'(i), pos_r, data);
    end
  end

  always_comb begin
    res.fire  = go && last;
    res.alive = alive_upd;
    res.count = {1'b0, pos_r} + imbc_pkg::CNT_W'(1);
    pos_nxt   = pos_r;
    alive_nxt = alive_r;
    if (go) begin
      if (last) begin
        pos_nxt   = '0;
        alive_nxt = imbc_pkg::ALL_ALIVE;
      end else begin
        pos_nxt   = (pos_r == imbc_pkg::POS_MAX) ? pos_r : pos_r + 5'd1;
        alive_nxt = alive_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      alive_r <= imbc_pkg::ALL_ALIVE;
    end else begin
      pos_r   <= pos_nxt;
      alive_r <= alive_nxt;
    end
  end

  `IMBC_ASSERT_NXT(a_rearm, go && last, pos_r == '0 && alive_r == imbc_pkg::ALL_ALIVE, "no rearm after final word")
  `IMBC_ASSERT_NXT(a_pos_step, go && !last && pos_r != imbc_pkg::POS_MAX, pos_r == $past(pos_r) + 5'd1, "position did not advance")
  `IMBC_ASSERT_NXT(a_alive_drop, go && !last, (alive_r & ~$past(alive_r)) == '0, "match bit came back mid-buffer")
  `IMBC_ASSERT_NXT(a_idle_hold, !go, $stable(pos_r) && $stable(alive_r), "state moved without a word")

endmodule

### rtl/imbc_result.sv
// Priority pick of the matched signature and the output register.
// Depends on imbc_pkg.
module imbc_result (
  input  logic                        clk,
  input  logic                        rst_n,
  input  imbc_pkg::match_res_t        res,
  output logic                        out_free,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [imbc_pkg::KIND_W-1:0] out_image_kind
);

  logic            valid_r, valid_nxt;
  imbc_pkg::kind_t kind_r, kind_nxt;
  imbc_pkg::kind_t pick;

  // lowest index wins
  always_comb begin
    pick = imbc_pkg::KIND_UNKNOWN;
    for (int i = imbc_pkg::SIG_COUNT - 1; i >= 0; i--) begin
      if (res.alive[i] && res.count >=
          {1'b0, imbc_pkg::sig_need(imbc_pkg::sig_t'(i))}) begin
        pick = imbc_pkg::sig_kind(imbc_pkg::sig_t'(i));
      end
    end
  end

  assign out_free       = !valid_r || !out_stall;
  assign out_valid      = valid_r;
  assign out_image_kind = kind_r;

  always_comb begin
    valid_nxt = valid_r;
    kind_nxt  = kind_r;
    if (out_free) begin
      valid_nxt = res.fire;
    end
    if (res.fire) begin
      kind_nxt = pick;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    kind_r <= kind_nxt;
  end

endmodule

### rtl/image_magic_byte_classifier.sv
// Top level of the image magic-byte classifier.
// Depends on imbc_pkg, imbc_in_stage, imbc_match and imbc_result.
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_stall   in_data_byte[7:0], in_is_last
//   out_     output     out_valid / out_stall out_image_kind[3:0]
//
// One word per cycle unless stalled; final word and kind are each registered.
// Per word: one compare per signature against the byte at the current position.
// Reset (rst_n low, synchronous) clears position and rearms every match bit.
// Only a final word stalls on a held result; other words keep flowing.
module image_magic_byte_classifier (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_data_byte,
  input  logic                        in_is_last,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [imbc_pkg::KIND_W-1:0] out_image_kind
);

  logic                 go;
  logic [7:0]           data;
  logic                 last;
  logic                 out_free;
  imbc_pkg::match_res_t res;

  imbc_in_stage u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_is_last   (in_is_last),
    .out_free     (out_free),
    .go           (go),
    .data         (data),
    .last         (last)
  );

  imbc_match u_match (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (go),
    .data  (data),
    .last  (last),
    .res   (res)
  );

  imbc_result u_result (
    .clk            (clk),
    .rst_n          (rst_n),
    .res            (res),
    .out_free       (out_free),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_image_kind (out_image_kind)
  );

endmodule
